>>> src/bspq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_pkg: shared types and constants of the bounded stable priority queue
// Operation codes, status codes, cell control and the capacity register width.
// ----------------------------------------------------------------------------
package bspq_pkg;

  // Width and reset value of the capacity register
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation carried by an input transaction
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Operation that every cell of the chain performs
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_e;

  // Control broadcast from the queue control to the whole chain
  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/bspq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_cell: one slot of the sorted entry chain
// Holds one priority and handle. On insert it keeps its entry, takes the new
// one or takes its left neighbour's; on pop it takes its right neighbour's.
// ----------------------------------------------------------------------------
module bspq_cell #(
  parameter int unsigned PRIO_BITS   = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire                      clk_i,
  input  wire bspq_pkg::cell_ctrl_t ctrl_i,
  input  wire                      occ_i,
  input  wire  [PRIO_BITS-1:0]     new_prio_i,
  input  wire  [HANDLE_BITS-1:0]   new_handle_i,
  input  wire                      left_disp_i,
  input  wire  [PRIO_BITS-1:0]     left_prio_i,
  input  wire  [HANDLE_BITS-1:0]   left_handle_i,
  input  wire  [PRIO_BITS-1:0]     right_prio_i,
  input  wire  [HANDLE_BITS-1:0]   right_handle_i,
  output logic                     disp_o,
  output logic [PRIO_BITS-1:0]     prio_o,
  output logic [HANDLE_BITS-1:0]   handle_o
);

  logic [PRIO_BITS-1:0]   prio_q, prio_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;

  // Displaced by an insert: slot free, or holding a strictly larger priority
  assign disp_o = !occ_i || (prio_q > new_prio_i);

  // Select the next slot contents
  always_comb begin
    prio_d   = prio_q;
    handle_d = handle_q;
    case (ctrl_i.op)
      bspq_pkg::OP_INSERT: begin
        if (disp_o) begin
          if (left_disp_i) begin
            prio_d   = left_prio_i;
            handle_d = left_handle_i;
          end else begin
            prio_d   = new_prio_i;
            handle_d = new_handle_i;
          end
        end
      end
      bspq_pkg::OP_POP: begin
        prio_d   = right_prio_i;
        handle_d = right_handle_i;
      end
      default: begin
        prio_d   = prio_q;
        handle_d = handle_q;
      end
    endcase
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    prio_q   <= prio_d;
    handle_q <= handle_d;
  end

  assign prio_o   = prio_q;
  assign handle_o = handle_q;

endmodule
`default_nettype wire

>>> src/bounded_stable_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_stable_priority_queue: stable min-priority queue of payload handles
// A sorted chain of cells; lowest priority at cell 0, equal priorities leave
// in arrival order. Inserts beyond the configured capacity are refused.
//
//   channel   direction  handshake                 payload
//   command   in         start, busy               kind, priority_req, handle
//   result    out        strobe_o (one cycle)      status, payload, priority,
//                                                  entry_count, queue_empty
//   config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (capacity)
//
// All cells compare against the new priority in parallel and shift on the
// same clock edge, so busy stays low and a command may be given in every
// cycle. The result is registered and appears in the cycle after acceptance,
// with strobe_o high for that cycle; it cannot be held off.
// Reset empties the queue and sets the capacity to 16; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_stable_priority_queue #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned PRIO_BITS   = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire                              kind_i,
  input  wire  [PRIO_BITS-1:0]             priority_req_i,
  input  wire  [HANDLE_BITS-1:0]           payload_handle_i,
  output logic                             strobe_o,
  output logic [1:0]                       status_o,
  output logic [HANDLE_BITS-1:0]           out_payload_o,
  output logic [PRIO_BITS-1:0]             out_priority_o,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count_o,
  output logic                             queue_empty_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [bspq_pkg::CAP_W-1:0]       cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [bspq_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       strobe_q;
  bspq_pkg::status_e          status_q, status_d;
  logic [HANDLE_BITS-1:0]     out_payload_q, out_payload_d;
  logic [PRIO_BITS-1:0]       out_priority_q, out_priority_d;
  logic                       accept;
  logic                       is_full;
  bspq_pkg::cell_ctrl_t       ctrl;

  logic                       disp_w   [DEPTH];
  logic [PRIO_BITS-1:0]       prio_w   [DEPTH];
  logic [HANDLE_BITS-1:0]     handle_w [DEPTH];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Full when the count reaches the capacity, saturated at the chain length
  assign is_full = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= 32'(DEPTH));

  // Decode the command into a chain operation and the next result
  always_comb begin
    ctrl.op        = bspq_pkg::OP_HOLD;
    count_d        = count_q;
    status_d       = bspq_pkg::ST_DONE;
    out_payload_d  = '0;
    out_priority_d = '0;
    if (accept) begin
      if (kind_i == bspq_pkg::KIND_INSERT) begin
        if (is_full) begin
          status_d = bspq_pkg::ST_FULL;
        end else begin
          ctrl.op = bspq_pkg::OP_INSERT;
          count_d = count_q + 1'b1;
        end
      end else begin
        if (count_q == '0) begin
          status_d = bspq_pkg::ST_EMPTY;
        end else begin
          ctrl.op        = bspq_pkg::OP_POP;
          count_d        = count_q - 1'b1;
          out_payload_d  = handle_w[0];
          out_priority_d = prio_w[0];
        end
      end
    end
  end

  // Chain of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   occ;
    logic                   left_disp;
    logic [PRIO_BITS-1:0]   left_prio, right_prio;
    logic [HANDLE_BITS-1:0] left_handle, right_handle;

    assign occ = CNT_W'(i) < count_q;

    if (i == 0) begin : g_head
      assign left_disp   = 1'b0;
      assign left_prio   = '0;
      assign left_handle = '0;
    end else begin : g_body
      assign left_disp   = disp_w[i-1];
      assign left_prio   = prio_w[i-1];
      assign left_handle = handle_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio   = '0;
      assign right_handle = '0;
    end else begin : g_inner
      assign right_prio   = prio_w[i+1];
      assign right_handle = handle_w[i+1];
    end

    bspq_cell #(
      .PRIO_BITS   (PRIO_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occ_i          (occ),
      .new_prio_i     (priority_req_i),
      .new_handle_i   (payload_handle_i),
      .left_disp_i    (left_disp),
      .left_prio_i    (left_prio),
      .left_handle_i  (left_handle),
      .right_prio_i   (right_prio),
      .right_handle_i (right_handle),
      .disp_o         (disp_w[i]),
      .prio_o         (prio_w[i]),
      .handle_o       (handle_w[i])
    );
  end

  // Control state: capacity, count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= bspq_pkg::CAP_RESET;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      count_q  <= count_d;
      strobe_q <= accept;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q       <= status_d;
      out_payload_q  <= out_payload_d;
      out_priority_q <= out_priority_d;
    end
  end

  assign strobe_o       = strobe_q;
  assign status_o       = status_q;
  assign out_payload_o  = out_payload_q;
  assign out_priority_o = out_priority_q;
  assign entry_count_o  = count_q;
  assign queue_empty_o  = (count_q == '0);

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> strobe_o)
    else $error("accepted command gave no result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("entry count beyond chain length");

  a_refused_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == bspq_pkg::ST_FULL) |-> $stable(count_q))
    else $error("refused insert changed the count");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == bspq_pkg::ST_EMPTY) |-> queue_empty_o)
    else $error("empty remove with entries held");
`endif

endmodule
`default_nettype wire
